/* src/ccg_pkg.sv */
// Shared types and constants for the cell color gradient pipeline.
package ccg_pkg;

    localparam int KEY_W  = 17;
    localparam int SPAN_W = 16;
    localparam int REM_W  = 26;
    localparam int BL_W   = 16;
    localparam int PROD_W = 32;

    // round(x / 255) as (x + 127) * 0x8081 >> 23, exact for x + 127 < 65793
    localparam logic [BL_W-1:0] RECIP_255 = 16'h8081;
    localparam int              RECIP_SH  = 23;
    localparam logic [BL_W-1:0] HALF_255  = 16'd127;
    localparam logic [7:0]      MAX_BYTE  = 8'd255;

    // Configuration register indexes
    localparam logic [2:0] REG_RANGE_START = 3'd0;
    localparam logic [2:0] REG_RANGE_END   = 3'd1;
    localparam logic [2:0] REG_COLOR_START = 3'd2;
    localparam logic [2:0] REG_COLOR_END   = 3'd3;
    localparam logic [2:0] REG_SOURCE      = 3'd4;
    localparam logic [2:0] REG_OVERWRITE   = 3'd5;

    // Key source codes
    localparam logic [2:0] SRC_RED    = 3'd0;
    localparam logic [2:0] SRC_GREEN  = 3'd1;
    localparam logic [2:0] SRC_BLUE   = 3'd2;
    localparam logic [2:0] SRC_ALPHA  = 3'd3;
    localparam logic [2:0] SRC_ROW    = 3'd4;
    localparam logic [2:0] SRC_COL    = 3'd5;
    localparam logic [2:0] SRC_HEIGHT = 3'd6;

    typedef struct packed {
        logic signed [15:0] range_start;
        logic signed [15:0] range_end;
        logic [31:0]        color_start;
        logic [31:0]        color_end;
        logic [2:0]         source;
        logic               overwrite;
    } cfg_t;

    // One cell in flight; later stages fill later fields
    typedef struct packed {
        logic [3:0][7:0]        pix;    // 0 red .. 3 alpha
        logic                   hit;
        logic                   zdx;
        logic [SPAN_W-1:0]      t;
        logic [SPAN_W-1:0]      dx;
        logic [3:0][REM_W-1:0]  rem;
        logic [3:0][7:0]        quo;
        logic [3:0][7:0]        newc;
        logic [2:0][BL_W-1:0]   bl;
        logic [2:0][PROD_W-1:0] prod;
    } item_t;

endpackage

/* src/ccg_front.sv */
// Key select, range test and interpolation numerator (two stages).
module ccg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  ccg_pkg::cfg_t     cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [3:0][7:0]   up_cell,
    input  logic signed [15:0] up_height,
    input  logic [11:0]       up_row,
    input  logic [11:0]       up_col,
    output logic              dn_valid,
    input  logic              dn_ready,
    output ccg_pkg::item_t    dn_item
);
    import ccg_pkg::*;

    logic  a_v_reg, b_v_reg;
    item_t a_reg, a_next, b_reg, b_next;
    logic  a_en, b_en;

    assign b_en     = !b_v_reg || dn_ready;
    assign a_en     = !a_v_reg || b_en;
    assign up_ready = a_en;
    assign dn_valid = b_v_reg;
    assign dn_item  = b_reg;

    // Stage A: pick key, test range, offset and span
    always_comb
    begin
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] rs;
        logic signed [KEY_W-1:0] re;
        logic                    has;
        key    = '0;
        has    = 1'b1;
        rs     = KEY_W'(cfg.range_start);
        re     = KEY_W'(cfg.range_end);
        case (cfg.source)
            SRC_RED:    key = KEY_W'({1'b0, up_cell[0]});
            SRC_GREEN:  key = KEY_W'({1'b0, up_cell[1]});
            SRC_BLUE:   key = KEY_W'({1'b0, up_cell[2]});
            SRC_ALPHA:  key = KEY_W'({1'b0, up_cell[3]});
            SRC_ROW:    key = KEY_W'({1'b0, up_row});
            SRC_COL:    key = KEY_W'({1'b0, up_col});
            SRC_HEIGHT: key = KEY_W'(up_height);
            default:    has = 1'b0;
        endcase
        a_next      = '0;
        a_next.pix  = up_cell;
        a_next.hit  = has && (key >= rs) && (key <= re);
        a_next.t    = SPAN_W'(key - rs);
        a_next.dx   = SPAN_W'(re - rs);
    end

    // Stage B: numerator c0*(dx-t) + c1*t, dividend 2*num + dx
    always_comb
    begin
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [23:0] num;
        b_next     = a_reg;
        b_next.zdx = (a_reg.dx == '0);
        for (int k = 0; k < 4; k++)
        begin
            c0  = cfg.color_start[31 - 8*k -: 8];
            c1  = cfg.color_end[31 - 8*k -: 8];
            num = 24'(c0 * (a_reg.dx - a_reg.t)) + 24'(c1 * a_reg.t);
            b_next.rem[k] = REM_W'({num, 1'b0}) + REM_W'(a_reg.dx);
            b_next.quo[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_v_reg <= up_valid;
            if (b_en)
                b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && up_valid)
            a_reg <= a_next;
        if (b_en && a_v_reg)
            b_reg <= b_next;
    end

endmodule

/* src/ccg_div_stage.sv */
// One divider stage: two quotient bits per lane by restoring division.
module ccg_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     step,
    input  logic           up_valid,
    output logic           up_ready,
    input  ccg_pkg::item_t up_item,
    output logic           dn_valid,
    input  logic           dn_ready,
    output ccg_pkg::item_t dn_item
);
    import ccg_pkg::*;

    logic  v_reg;
    item_t d_reg, d_next;
    logic  en;

    assign en       = !v_reg || dn_ready;
    assign up_ready = en;
    assign dn_valid = v_reg;
    assign dn_item  = d_reg;

    // Divisor is 2*dx; bit position counts down from 7
    always_comb
    begin
        logic [2:0]       pos;
        logic [REM_W-1:0] ds;
        d_next = up_item;
        for (int j = 0; j < 2; j++)
        begin
            pos = 3'd7 - {step, 1'(j)};
            ds  = REM_W'(up_item.dx) << ({1'b0, pos} + 4'd1);
            for (int k = 0; k < 4; k++)
            begin
                if (d_next.rem[k] >= ds)
                begin
                    d_next.rem[k]      = d_next.rem[k] - ds;
                    d_next.quo[k][pos] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && up_valid)
            d_reg <= d_next;
    end

endmodule

/* src/ccg_back.sv */
// Alpha blend against the gradient color and output select (three stages).
module ccg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ccg_pkg::cfg_t  cfg,
    input  logic           up_valid,
    output logic           up_ready,
    input  ccg_pkg::item_t up_item,
    output logic           dn_valid,
    input  logic           dn_ready,
    output logic [7:0]     dn_red,
    output logic [7:0]     dn_green,
    output logic [7:0]     dn_blue,
    output logic [7:0]     dn_alpha,
    output logic           dn_hit
);
    import ccg_pkg::*;

    logic       e_v_reg, f_v_reg, o_v_reg;
    item_t      e_reg, e_next, f_reg, f_next;
    logic [3:0][7:0] o_reg, o_next;
    logic       o_hit_reg;
    logic       e_en, f_en, o_en;

    assign o_en     = !o_v_reg || dn_ready;
    assign f_en     = !f_v_reg || o_en;
    assign e_en     = !e_v_reg || f_en;
    assign up_ready = e_en;
    assign dn_valid = o_v_reg;
    assign dn_red   = o_reg[0];
    assign dn_green = o_reg[1];
    assign dn_blue  = o_reg[2];
    assign dn_alpha = o_reg[3];
    assign dn_hit   = o_hit_reg;

    // Stage E: gradient color and blend sum |old-new|*a + new*(255-a) + 127
    always_comb
    begin
        logic [7:0] n;
        logic [7:0] d;
        logic [7:0] a;
        e_next = up_item;
        a      = up_item.pix[3];
        for (int k = 0; k < 4; k++)
            e_next.newc[k] = up_item.zdx ? cfg.color_start[31 - 8*k -: 8] : up_item.quo[k];
        for (int k = 0; k < 3; k++)
        begin
            n = e_next.newc[k];
            d = (up_item.pix[k] >= n) ? up_item.pix[k] - n : n - up_item.pix[k];
            e_next.bl[k] = BL_W'(d * a) + BL_W'(n * (MAX_BYTE - a)) + HALF_255;
        end
    end

    // Stage F: divide by 255 through the reciprocal
    always_comb
    begin
        f_next = e_reg;
        for (int k = 0; k < 3; k++)
            f_next.prod[k] = e_reg.bl[k] * RECIP_255;
    end

    // Stage O: pick pass-through, overwrite or blend
    always_comb
    begin
        if (!f_reg.hit)
            o_next = f_reg.pix;
        else if (cfg.overwrite)
            o_next = f_reg.newc;
        else
        begin
            for (int k = 0; k < 3; k++)
                o_next[k] = f_reg.prod[k][RECIP_SH +: 8];
            o_next[3] = f_reg.pix[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
                e_v_reg <= up_valid;
            if (f_en)
                f_v_reg <= e_v_reg;
            if (o_en)
                o_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_en && up_valid)
            e_reg <= e_next;
        if (f_en && e_v_reg)
            f_reg <= f_next;
        if (o_en && f_v_reg)
        begin
            o_reg     <= o_next;
            o_hit_reg <= f_reg.hit;
        end
    end

endmodule

/* src/cell_color_gradient.sv */
// Top level: configuration registers and the nine-stage gradient pipeline.
//
//  channel | handshake            | words
//  in      | in_valid / in_ready  | cell_red.. col_index
//  out     | out_valid/ out_ready | out_red.. in_range
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// The pipeline has two front stages, four divider stages (two quotient
// bits each), three blend and output stages. One cell enters per cycle unless the output stalls.
// Each stage holds its word while the next one cannot take it, so stalls lose nothing.
// Reset clears valid bits and loads the register defaults.
// cfg_ready is always high.
module cell_color_gradient (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        cell_red,
    input  logic [7:0]        cell_green,
    input  logic [7:0]        cell_blue,
    input  logic [7:0]        cell_alpha,
    input  logic signed [15:0] cell_height,
    input  logic [11:0]       row_index,
    input  logic [11:0]       col_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic [7:0]        out_alpha,
    output logic              in_range,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ccg_pkg::*;

    cfg_t  cfg_reg;
    logic  f_valid, f_ready;
    item_t f_item;
    logic  [4:0] d_valid, d_ready;
    item_t d_item [5];

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_start <= 16'sd0;
            cfg_reg.range_end   <= 16'sd255;
            cfg_reg.color_start <= 32'h0000_0000;
            cfg_reg.color_end   <= 32'hFFFF_FFFF;
            cfg_reg.source      <= SRC_HEIGHT;
            cfg_reg.overwrite   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RANGE_START: cfg_reg.range_start <= cfg_data[15:0];
                REG_RANGE_END:   cfg_reg.range_end   <= cfg_data[15:0];
                REG_COLOR_START: cfg_reg.color_start <= cfg_data;
                REG_COLOR_END:   cfg_reg.color_end   <= cfg_data;
                REG_SOURCE:      cfg_reg.source      <= cfg_data[2:0];
                REG_OVERWRITE:   cfg_reg.overwrite   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    ccg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .up_cell   ({cell_alpha, cell_blue, cell_green, cell_red}),
        .up_height (cell_height),
        .up_row    (row_index),
        .up_col    (col_index),
        .dn_valid  (f_valid),
        .dn_ready  (f_ready),
        .dn_item   (f_item)
    );

    assign d_valid[0] = f_valid;
    assign f_ready    = d_ready[0];
    assign d_item[0]  = f_item;

    // Divider chain
    for (genvar s = 0; s < 4; s++)
    begin : g_div
        ccg_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (2'(s)),
            .up_valid (d_valid[s]),
            .up_ready (d_ready[s]),
            .up_item  (d_item[s]),
            .dn_valid (d_valid[s+1]),
            .dn_ready (d_ready[s+1]),
            .dn_item  (d_item[s+1])
        );
    end

    ccg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (d_valid[4]),
        .up_ready (d_ready[4]),
        .up_item  (d_item[4]),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_red   (out_red),
        .dn_green (out_green),
        .dn_blue  (out_blue),
        .dn_alpha (out_alpha),
        .dn_hit   (in_range)
    );

endmodule

/* src/ccg_checker.sv */
// Port-level checks for the cell color gradient pipeline.
module ccg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic       in_range
);
    logic [3:0] cnt_reg, cnt_next;

    // Words inside the pipeline
    always_comb
    begin
        cnt_next = cnt_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_depth: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 4'd9)
        else $error("more words in flight than stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 4'd0)
        else $error("output word with nothing accepted");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && cnt_reg == 4'd9)
        else $error("input stalled while pipeline has room");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(in_range))
        else $error("stalled output word changed");

endmodule

bind cell_color_gradient ccg_checker u_ccg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .in_range  (in_range)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the cell color gradient pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccg_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       hit;
    } pixel_t;

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Scoreboard: predicts each cell and checks results in order
    class gradient_board;
        longint start_key, end_key;
        logic [31:0] color_lo, color_hi;
        logic [2:0] source;
        logic overwrite;
        pixel_t pending[$];

        function new();
            start_key = 0; end_key = 255;
            color_lo = 32'h0; color_hi = 32'hFFFF_FFFF;
            source = SRC_HEIGHT; overwrite = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_RANGE_START: start_key = longint'($signed(data[15:0]));
                REG_RANGE_END:   end_key = longint'($signed(data[15:0]));
                REG_COLOR_START: color_lo = data;
                REG_COLOR_END:   color_hi = data;
                REG_SOURCE:      source = data[2:0];
                REG_OVERWRITE:   overwrite = data[0];
                default: ;
            endcase
        endfunction

        // half away from zero, den > 0
        function longint round_div(longint num, longint den);
            if (num >= 0) return (2 * num + den) / (2 * den);
            return -((2 * (-num) + den) / (2 * den));
        endfunction

        function logic [7:0] sat_byte(longint v);
            if (v < 0) return 8'd0;
            if (v > 255) return 8'd255;
            return v[7:0];
        endfunction

        function logic [7:0] lerp(int lane, longint key);
            longint c0, c1, span;
            c0 = longint'(color_lo[31-8*lane -: 8]);
            c1 = longint'(color_hi[31-8*lane -: 8]);
            span = end_key - start_key;
            if (span <= 0) return c0[7:0];
            return sat_byte(round_div(c0 * span + (key - start_key) * (c1 - c0), span));
        endfunction

        function logic [7:0] mix(logic [7:0] prior, logic [7:0] fresh, logic [7:0] a);
            longint d;
            d = longint'(prior) - longint'(fresh);
            if (d < 0) d = -d;
            return sat_byte(round_div(d * a + longint'(fresh) * (255 - longint'(a)), 255));
        endfunction

        function void note_cell(logic [7:0] c [4], logic signed [15:0] h,
                                logic [11:0] r, logic [11:0] col);
            pixel_t p;
            longint key;
            logic [7:0] g [4];
            bit valid_key;
            valid_key = 1;
            key = 0;
            case (source)
                SRC_RED, SRC_GREEN, SRC_BLUE, SRC_ALPHA: key = longint'(c[source]);
                SRC_ROW:    key = longint'(r);
                SRC_COL:    key = longint'(col);
                SRC_HEIGHT: key = longint'(h);
                default:    valid_key = 0;
            endcase
            if (valid_key && start_key <= key && key <= end_key)
            begin
                for (int k = 0; k < 4; k++) g[k] = lerp(k, key);
                if (overwrite)
                begin
                    p.red = g[0]; p.green = g[1]; p.blue = g[2]; p.alpha = g[3];
                end
                else
                begin
                    p.red = mix(c[0], g[0], c[3]);
                    p.green = mix(c[1], g[1], c[3]);
                    p.blue = mix(c[2], g[2], c[3]);
                    p.alpha = c[3];
                end
                p.hit = 1'b1;
            end
            else
            begin
                p.red = c[0]; p.green = c[1]; p.blue = c[2]; p.alpha = c[3];
                p.hit = 1'b0;
            end
            pending.push_back(p);
        endfunction

        task check_cell(pixel_t got);
            pixel_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
            if (got.green !== want.green) report_mismatch("out_green", got.green, want.green);
            if (got.blue !== want.blue) report_mismatch("out_blue", got.blue, want.blue);
            if (got.alpha !== want.alpha) report_mismatch("out_alpha", got.alpha, want.alpha);
            if (got.hit !== want.hit) report_mismatch("in_range", got.hit, want.hit);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
    logic in_ready, out_valid, cfg_ready, in_range;
    logic [7:0] cell_red = '0, cell_green = '0, cell_blue = '0, cell_alpha = '0;
    logic signed [15:0] cell_height = '0;
    logic [11:0] row_index = '0, col_index = '0;
    logic [7:0] out_red, out_green, out_blue, out_alpha;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int stall_left = 0;

    gradient_board board = new();

    cell_color_gradient u_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_cell(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic [15:0] h, logic [11:0] row, logic [11:0] col);
        int gap;
        logic [7:0] c [4];
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cell_red <= r; cell_green <= g; cell_blue <= b; cell_alpha <= a;
        cell_height <= h; row_index <= row; col_index <= col;
        do @(posedge clk); while (!in_ready);
        c[0] = r; c[1] = g; c[2] = b; c[3] = a;
        board.note_cell(c, h, row, col);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_cell();
        logic [15:0] h;
        if ($urandom_range(0, 3) == 0) h = 16'($urandom_range(0, 600) - 300);
        else h = 16'($urandom());
        send_cell(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()), h,
                  12'($urandom()), 12'($urandom()));
    endtask

    // receiver: one ready cycle, then a random stall, which may be empty
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.red = out_red; got.green = out_green; got.blue = out_blue;
            got.alpha = out_alpha; got.hit = in_range;
            board.check_cell(got);
        end
    end

    initial
    begin
        int lo, hi;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, height extremes
        send_cell(8'h00, 8'hFF, 8'h80, 8'h00, 16'sh0000, 12'h000, 12'hFFF);
        send_cell(8'hFF, 8'h00, 8'h7F, 8'hFF, 16'sh00FF, 12'hFFF, 12'h000);
        send_cell(8'h12, 8'h34, 8'h56, 8'h80, 16'sh0080, 12'h001, 12'h001);
        send_cell(8'h12, 8'h34, 8'h56, 8'h80, 16'sh8000, 12'h001, 12'h001);
        send_cell(8'h12, 8'h34, 8'h56, 8'h80, 16'sh7FFF, 12'h001, 12'h001);
        send_cell(8'h12, 8'h34, 8'h56, 8'h80, 16'shFFFF, 12'h001, 12'h001);
        drain();
        // full signed range, overwrite, every source
        write_reg(REG_RANGE_START, 32'h0000_8000);
        write_reg(REG_RANGE_END, 32'h0000_7FFF);
        write_reg(REG_COLOR_START, 32'hFF00_80FF);
        write_reg(REG_COLOR_END, 32'h00FF_7F00);
        write_reg(REG_OVERWRITE, 32'h1);
        for (int s = 0; s < 8; s++)
        begin
            drain();
            write_reg(REG_SOURCE, s);
            send_cell(8'hFF, 8'h00, 8'hA5, 8'h5A, 16'sh8000, 12'hFFF, 12'h000);
            send_cell(8'h00, 8'hFF, 8'h5A, 8'hA5, 16'sh7FFF, 12'h000, 12'hFFF);
        end
        drain();
        // zero-width range and empty range
        write_reg(REG_SOURCE, SRC_RED);
        write_reg(REG_RANGE_START, 32'd100);
        write_reg(REG_RANGE_END, 32'd100);
        send_cell(8'd100, 8'd1, 8'd2, 8'd3, 16'sd0, 12'd0, 12'd0);
        send_cell(8'd101, 8'd1, 8'd2, 8'd3, 16'sd0, 12'd0, 12'd0);
        drain();
        write_reg(REG_RANGE_START, 32'd200);
        send_cell(8'd150, 8'd1, 8'd2, 8'd3, 16'sd0, 12'd0, 12'd0);
        drain();

        // random phases
        for (int phase = 0; phase < 18; phase++)
        begin
            write_reg(REG_SOURCE, (phase % 9 == 8) ? 3'd7 : $urandom_range(0, 6));
            write_reg(REG_OVERWRITE, $urandom_range(0, 1));
            write_reg(REG_COLOR_START, (phase % 5 == 0) ? 32'h0 : $urandom());
            write_reg(REG_COLOR_END, (phase % 5 == 1) ? 32'hFFFF_FFFF : $urandom());
            case (phase % 4)
                0:
                begin
                    lo = $urandom_range(0, 128); hi = lo + $urandom_range(0, 200);
                end
                1:
                begin
                    lo = $urandom_range(0, 2000); hi = lo + $urandom_range(0, 2000);
                end
                2:
                begin
                    lo = -32768; hi = 32767;
                end
                default:
                begin
                    lo = $urandom_range(0, 600) - 300; hi = lo + $urandom_range(0, 3);
                end
            endcase
            if (phase == 7)
            begin
                lo = 50; hi = 10;
            end
            write_reg(REG_RANGE_START, lo);
            write_reg(REG_RANGE_END, hi);
            for (int n = 0; n < 100; n++)
            begin
                if (board.source == SRC_ROW || board.source == SRC_COL)
                begin
                    if ($urandom_range(0, 2) != 0)
                        send_cell(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                  8'($urandom()), 16'($urandom()),
                                  12'($urandom_range(0, 600)), 12'($urandom_range(0, 600)));
                    else random_cell();
                end
                else random_cell();
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("cell_color_gradient regression: pass");
        else
            $display("cell_color_gradient regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("cell_color_gradient regression: fail");
        $finish;
    end
endmodule
